/* hw/rtl/sbt_pkg.sv */
// Shared payload and control types for the sorted balanced tree block.
package sbt_pkg;

	localparam int VAL_W = 32;

	typedef struct packed {
		logic signed [VAL_W-1:0] item_value;
		logic                    batch_end;
	} in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] out_value;
		logic                    out_last;
		logic                    overflow;
	} out_t;

	typedef struct packed {
		logic ins;
		logic shift;
		logic valid;
		logic at_end;
	} cell_ctrl_t;

endpackage

/* hw/rtl/sbt_cell.sv */
// One sorting cell: holds a value, makes room for an insert, shifts down on drain.
module sbt_cell (
	input  logic                                clk,
	input  sbt_pkg::cell_ctrl_t                 ctrl,
	input  logic signed [sbt_pkg::VAL_W-1:0]    key,
	input  logic signed [sbt_pkg::VAL_W-1:0]    left_val,
	input  logic                                left_gt,
	input  logic signed [sbt_pkg::VAL_W-1:0]    right_val,
	output logic signed [sbt_pkg::VAL_W-1:0]    val,
	output logic                                gt
);

	logic signed [sbt_pkg::VAL_W-1:0] val_q;

	assign val = val_q;
	assign gt  = ctrl.valid && (val_q > key);

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= right_val;
		end else if (ctrl.ins && (ctrl.at_end || gt)) begin
			val_q <= left_gt ? left_val : key;
		end
	end

endmodule

/* hw/rtl/sbt_walk.sv */
// Sorted value store and post-order range walk over an explicit range stack.
module sbt_walk #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1)-1:0] wr_addr,
	input  logic signed [sbt_pkg::VAL_W-1:0] wr_data,
	input  logic                             go,
	input  logic [((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1)-1:0] go_hi,
	input  logic                             ovf,
	output logic                             active,
	output logic                             strobe,
	output sbt_pkg::out_t                    result
);

	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int SD = 2 * $clog2(MAX_ITEMS + 1) + 2;
	localparam int PW = $clog2(SD + 1);
	localparam int TW = $clog2(SD);

	typedef struct packed {
		logic [IW-1:0] lo;
		logic [IW-1:0] hi;
		logic          expd;
	} frame_t;

	logic signed [sbt_pkg::VAL_W-1:0] mem [MAX_ITEMS];
	frame_t                           stk_q [SD];
	logic [PW-1:0]                    sp_q;
	logic signed [sbt_pkg::VAL_W-1:0] rd_s1;
	logic                             emit_s1;
	logic                             last_s1;

	frame_t        top;
	logic [TW-1:0] top_idx;
	logic [TW-1:0] p1_idx;
	logic [TW-1:0] p2_idx;
	logic [IW-1:0] mid;
	logic          has_r;
	logic          has_l;
	logic          emit;

	assign active  = (sp_q != '0);
	assign top_idx = TW'(sp_q - PW'(1));
	assign top     = stk_q[top_idx];
	assign mid     = IW'(({1'b0, top.lo} + {1'b0, top.hi}) >> 1);
	assign has_r   = (mid < top.hi);
	assign has_l   = (top.lo < mid);
	assign p1_idx  = TW'(sp_q);
	assign p2_idx  = TW'(sp_q + PW'(has_r));
	assign emit    = active && top.expd;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (emit) begin
			rd_s1 <= mem[mid];
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			stk_q[0] <= '{lo: '0, hi: go_hi, expd: 1'b0};
		end else if (active && !top.expd) begin
			stk_q[top_idx].expd <= 1'b1;
			if (has_r) begin
				stk_q[p1_idx] <= '{lo: mid + IW'(1), hi: top.hi, expd: 1'b0};
			end
			if (has_l) begin
				stk_q[p2_idx] <= '{lo: top.lo, hi: mid - IW'(1), expd: 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			emit_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			emit_s1 <= emit;
			last_s1 <= emit && (sp_q == PW'(1));
			if (go) begin
				sp_q <= PW'(1);
			end else if (emit) begin
				sp_q <= sp_q - PW'(1);
			end else if (active) begin
				sp_q <= sp_q + PW'(has_r) + PW'(has_l);
			end
		end
	end

	assign strobe          = emit_s1;
	assign result.out_value = rd_s1;
	assign result.out_last  = last_s1;
	assign result.overflow  = ovf;

endmodule

/* hw/rtl/sorted_balanced_tree_postorder.sv */
// Top level: batch collector that emits its values in balanced search tree post-order.
//
// Input: an item (value plus batch_end) is taken at a rising edge where start is high
// and busy is low. While collecting, one item is taken every cycle; each value is
// inserted in ascending order into a row of MAX_ITEMS sorting cells, after any equal
// values. Values past MAX_ITEMS are dropped and the batch's results flag overflow.
// An item with batch_end high inserts its value, then busy rises and:
//   - the row drains into the value store, one value per cycle;
//   - a range-stack walk expands each index range and then, once its sub-ranges are
//     done, emits its midpoint, one result at most per cycle.
// Each result sits on result for one cycle with strobe high; the receiver cannot stall,
// so results are never held. out_last marks the final beat. busy falls in the cycle
// after the final beat. The first result comes from the first node in post-order, at
// depth at most floor(log2 n); busy stays high through the drain and the walk.
// Reset clears the fill count, drop flag, state and walk stack pointer; stored values need none.
module sorted_balanced_tree_postorder #(
	parameter int MAX_ITEMS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sbt_pkg::in_t  item,
	output logic          strobe,
	output sbt_pkg::out_t result
);

	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] fill_q;
	logic          drop_q;
	logic          ovf_q;
	logic [CW-1:0] drain_cnt_q;
	logic [CW-1:0] drain_n_q;

	logic          accept;
	logic          full;
	logic          ins_en;
	logic          shift_en;
	logic          drain_done;
	logic          walk_go;
	logic          walk_active;

	logic signed [sbt_pkg::VAL_W-1:0] cell_val [MAX_ITEMS];
	logic                             cell_gt  [MAX_ITEMS];

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign full       = (fill_q == CW'(MAX_ITEMS));
	assign ins_en     = accept && !full;
	assign shift_en   = (state_q == ST_DRAIN);
	assign drain_done = (drain_cnt_q == drain_n_q - CW'(1));
	assign walk_go    = shift_en && drain_done;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		sbt_pkg::cell_ctrl_t              ctrl;
		logic signed [sbt_pkg::VAL_W-1:0] left_val;
		logic                             left_gt;
		logic signed [sbt_pkg::VAL_W-1:0] right_val;

		assign ctrl.ins    = ins_en;
		assign ctrl.shift  = shift_en;
		assign ctrl.valid  = (CW'(i) < fill_q);
		assign ctrl.at_end = (CW'(i) == fill_q);

		if (i == 0) begin : g_first
			assign left_val = item.item_value;
			assign left_gt  = 1'b0;
		end else begin : g_inner
			assign left_val = cell_val[i-1];
			assign left_gt  = cell_gt[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_last
			assign right_val = cell_val[i];
		end else begin : g_mid
			assign right_val = cell_val[i+1];
		end

		sbt_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.key       (item.item_value),
			.left_val  (left_val),
			.left_gt   (left_gt),
			.right_val (right_val),
			.val       (cell_val[i]),
			.gt        (cell_gt[i])
		);
	end

	sbt_walk #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (shift_en),
		.wr_addr (drain_cnt_q[IW-1:0]),
		.wr_data (cell_val[0]),
		.go      (walk_go),
		.go_hi   (IW'(drain_n_q - CW'(1))),
		.ovf     (ovf_q),
		.active  (walk_active),
		.strobe  (strobe),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			drop_q      <= 1'b0;
			ovf_q       <= 1'b0;
			drain_cnt_q <= '0;
			drain_n_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.batch_end) begin
							drain_n_q   <= full ? fill_q : fill_q + CW'(1);
							ovf_q       <= drop_q || full;
							fill_q      <= '0;
							drop_q      <= 1'b0;
							drain_cnt_q <= '0;
							state_q     <= ST_DRAIN;
						end else begin
							fill_q <= full ? fill_q : fill_q + CW'(1);
							drop_q <= drop_q || full;
						end
					end
				end
				ST_DRAIN: begin
					drain_cnt_q <= drain_cnt_q + CW'(1);
					if (drain_done) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (!walk_active) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(MAX_ITEMS))
		else $error("fill count beyond capacity");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.out_last |=> !strobe)
		else $error("result beat after final beat");

	a_no_beat_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> !strobe)
		else $error("result beat while draining");

	a_go_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		walk_go |-> drain_n_q != '0)
		else $error("walk started on empty batch");

endmodule

/* bench/testbench.sv */
// Self-checking bench for the sorted balanced tree post-order block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 64;

	typedef struct packed {
		sbt_pkg::in_t beat;
		logic         hold;
	} pending_t;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	sbt_pkg::in_t  item = '0;
	logic          busy;
	logic          strobe;
	sbt_pkg::out_t result;

	pending_t      pending_beats[$];
	sbt_pkg::out_t postorder_q[$];

	logic signed [sbt_pkg::VAL_W-1:0] ordered_vals [CAPACITY];
	int   held_count = 0;
	logic lost_flag = 1'b0;
	int   walk_n;
	int   fail_count = 0;
	int   burst_left = 0;
	int   gap_left = 0;
	int   queued_items = 0;
	sbt_pkg::out_t want;

	sorted_balanced_tree_postorder #(.MAX_ITEMS(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void sort_in(logic signed [sbt_pkg::VAL_W-1:0] key);
		int p;
		if (held_count >= CAPACITY) begin
			lost_flag = 1'b1;
			return;
		end
		p = held_count;
		while (p > 0 && ordered_vals[p-1] > key) begin
			ordered_vals[p] = ordered_vals[p-1];
			p--;
		end
		ordered_vals[p] = key;
		held_count++;
	endfunction

	function automatic void walk_span(int lo, int hi);
		int            mid;
		sbt_pkg::out_t r;
		if (lo > hi)
			return;
		mid = (lo + hi) / 2;
		walk_span(lo, mid - 1);
		walk_span(mid + 1, hi);
		r.out_value = ordered_vals[mid];
		r.out_last = (walk_n == held_count - 1);
		r.overflow = lost_flag;
		postorder_q = {postorder_q, r};
		walk_n++;
	endfunction

	function automatic void apply_beat(sbt_pkg::in_t b);
		sort_in(b.item_value);
		if (b.batch_end) begin
			walk_n = 0;
			walk_span(0, held_count - 1);
			held_count = 0;
			lost_flag = 1'b0;
		end
	endfunction

	function automatic void add_beat(logic signed [sbt_pkg::VAL_W-1:0] v, logic last,
	                                 logic hold);
		pending_t p;
		p.beat.item_value = v;
		p.beat.batch_end = last;
		p.hold = hold;
		pending_beats = {pending_beats, p};
		queued_items++;
	endfunction

	function automatic logic signed [sbt_pkg::VAL_W-1:0] pick_value();
		int k;
		k = $urandom_range(0, 5);
		case (k)
			3: begin
				k = $urandom_range(0, 8);
				return k - 4;
			end
			4: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			5: begin
				k = $urandom_range(0, 7);
				return $urandom_range(0, 1) ? 32'sh8000_0000 + k : 32'sh7FFF_FFFF - k;
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_batch(int n, logic hold);
		for (int i = 0; i < n; i++)
			add_beat(pick_value(), i == n - 1, hold && i == 0);
	endfunction

	// sender: bursts of beats separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			burst_left = $urandom_range(1, 24);
			gap_left = 0;
		end else if (!(start && busy)) begin
			if (start) begin
				apply_beat(item);
				void'(pending_beats.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_beats.size() != 0 &&
			             !(pending_beats[0].hold && postorder_q.size() != 0)) begin
				start <= 1'b1;
				item <= pending_beats[0].beat;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// receiver: every strobe is a beat that must match the oldest prediction
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (postorder_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected beat: value %0d last %0b overflow %0b",
					         result.out_value, result.out_last, result.overflow);
			end else begin
				want = postorder_q.pop_front();
				if (result.out_value !== want.out_value ||
				    result.out_last !== want.out_last ||
				    result.overflow !== want.overflow) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
						         want.out_value, want.out_last, want.overflow,
						         result.out_value, result.out_last, result.overflow);
				end
			end
		end
	end

	initial begin
		int n;
		add_beat(32'sh8000_0000, 1'b1, 1'b0);
		add_beat(32'sh7FFF_FFFF, 1'b1, 1'b0);
		add_beat(32'sd0, 1'b1, 1'b0);
		add_beat(32'sh7FFF_FFFF, 1'b0, 1'b0);
		add_beat(32'sh8000_0000, 1'b0, 1'b0);
		add_beat(-32'sd1, 1'b0, 1'b0);
		add_beat(32'sd1, 1'b0, 1'b0);
		add_beat(-32'sd1, 1'b0, 1'b0);
		add_beat(32'sd0, 1'b0, 1'b0);
		add_beat(32'sh5555_5555, 1'b0, 1'b0);
		add_beat(32'shAAAA_AAAA, 1'b1, 1'b0);
		for (int i = 0; i < 7; i++)
			add_beat(32'sd42, i == 6, 1'b0);
		for (int i = 0; i < 6; i++)
			add_beat(32'sd10 - i, i == 5, 1'b0);

		add_batch(CAPACITY, 1'b1);
		add_batch(CAPACITY + 1, 1'b0);
		while (queued_items < 400) begin
			if ($urandom_range(0, 11) == 0) begin
				case ($urandom_range(0, 3))
					0: n = CAPACITY - 1;
					1: n = CAPACITY;
					2: n = CAPACITY + 1;
					default: n = $urandom_range(CAPACITY + 2, CAPACITY + 8);
				endcase
			end else begin
				n = $urandom_range(1, 12);
			end
			add_batch(n, $urandom_range(0, 7) == 0);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0)
			@(posedge clk);
		while (postorder_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

/* files.f */
hw/rtl/sbt_pkg.sv
hw/rtl/sbt_cell.sv
hw/rtl/sbt_walk.sv
hw/rtl/sorted_balanced_tree_postorder.sv
bench/testbench.sv
